// ===== sv/mgm_pkg.sv =====
// Shared types and constants of the masked 3-D gradient magnitude unit.
package mgm_pkg;

    localparam int CFG_W = 9;      // width of a size register
    localparam int CW    = 13;     // width for sizes and coordinate compares
    localparam int INT_W = 16;     // intensity field width
    localparam int MAG_W = 21;     // magnitude field width

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        CMD_VOXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [INT_W-1:0] intensity;
    } in_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last;
    } out_t;

    // Control that travels alongside data through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

// ===== sv/mgm_bank.sv =====
// One bank of the plane store: one write port, one registered read port.
module mgm_bank #(
    parameter int DW = 16,
    parameter int AW = 14
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mgm_sqrt.sv =====
// Pipelined rounded integer square root, one result bit per stage.
module mgm_sqrt #(
    parameter int K = 21
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  mgm_pkg::tag_t   in_tag,
    input  logic [2*K-1:0]  in_rad,
    output mgm_pkg::tag_t   out_tag,
    output logic [K-1:0]    out_root
);

    mgm_pkg::tag_t   tag_reg [K+1];
    logic [K-1:0]    q_reg   [K+1];
    logic [K+1:0]    r_reg   [K+1];
    logic [2*K-1:0]  n_reg   [K];
    mgm_pkg::tag_t   out_tag_reg;
    logic [K-1:0]    root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0] <= '0;
            r_reg[0] <= '0;
            n_reg[0] <= in_rad;
        end
    end

    for (genvar i = 0; i < K; i++) begin : g_step
        logic [K+1:0] sh;
        logic [K+1:0] trial;
        logic         ge;

        assign sh    = {r_reg[i][K-1:0], n_reg[i][2*K-1 -: 2]};
        assign trial = {q_reg[i], 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[i+1] <= '0;
            end else if (en) begin
                tag_reg[i+1] <= tag_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i+1] <= {q_reg[i][K-2:0], ge};
                r_reg[i+1] <= ge ? (sh - trial) : sh;
            end
        end

        if (i < K - 1) begin : g_shift
            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[i+1] <= {n_reg[i][2*K-3:0], 2'b00};
                end
            end
        end
    end

    // Round to nearest: bump when the remainder exceeds the root.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_tag_reg <= '0;
        end else if (en) begin
            out_tag_reg <= tag_reg[K];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= q_reg[K] + K'(r_reg[K] > {2'b00, q_reg[K]});
        end
    end

    assign out_tag  = out_tag_reg;
    assign out_root = root_reg;

endmodule

// ===== sv/masked_gradient_magnitude_3d_unit.sv =====
// Top level of the masked 3-D gradient magnitude unit.
//
// Voxels enter in raster order (x fastest, then y, then z) and one gradient
// magnitude leaves per voxel, one plane behind the input; flush transactions
// sent after the final voxel drain the last plane, and a flush sent earlier
// is taken and produces nothing. The unit takes one transaction per clock
// when the output side keeps up; each result passes through the bank read,
// the difference and square stages, the one-bit-per-stage square root
// pipeline and the output register. The two-plane store is split into
// twelve banks, each with one write and one read port (plane parity x row
// mod 3 x column parity), so that the center, its right and both row
// neighbors and the voxel of the plane below are all read in the same cycle;
// the left neighbor is the previous center, held in a register. The store
// has no reset and needs no clearing pass: the streaming order never reads
// an entry before it is written. A write on the config channel restarts the
// volume and must only be issued while the unit is idle. Border voxels use a
// one-sided difference, an axis of size one contributes nothing, and a voxel
// whose intensity is not positive gives zero. Output: unsigned, 4 fraction
// bits.
module masked_gradient_magnitude_3d_unit #(
    parameter int MAX_X       = 256,
    parameter int MAX_Y       = 256,
    parameter int MAX_Z       = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mgm_pkg::in_t                s_data,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output mgm_pkg::out_t               m_data,
    // register write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [mgm_pkg::CFG_W-1:0]   cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int K      = SB + 5;            // root bits
    localparam int NW     = 2 * K;             // radicand bits
    localparam int SW     = 2 * SB + 4;        // sum of the three terms
    localparam int CW     = mgm_pkg::CW;
    localparam int XB     = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YB     = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZB     = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int XH     = (MAX_X + 1) / 2;
    localparam int XHB    = (XH > 1) ? $clog2(XH) : 1;
    localparam int R3     = (MAX_Y + 2) / 3;
    localparam int RB     = (R3 > 1) ? $clog2(R3) : 1;
    localparam int AW     = RB + XHB;
    localparam int NBANK  = 12;

    localparam logic [CW-1:0] MaxXC = CW'(MAX_X);
    localparam logic [CW-1:0] MaxYC = CW'(MAX_Y);
    localparam logic [CW-1:0] MaxZC = CW'(MAX_Z);

    // Size registers clamp to 1..MAX on use.
    function automatic logic [CW-1:0] eff_size(logic [mgm_pkg::CFG_W-1:0] v,
                                               logic [CW-1:0] mx);
        logic [CW-1:0] w;
        w = CW'(v);
        if (v == '0) begin
            return CW'(1);
        end else if (w > mx) begin
            return mx;
        end
        return w;
    endfunction

    // Bank number from plane parity, row mod 3 and column parity.
    function automatic logic [3:0] bidx(logic s, logic [1:0] yb, logic xp);
        return (s ? 4'd6 : 4'd0) + {1'b0, yb, 1'b0} + {3'b000, xp};
    endfunction

    function automatic logic [SB-1:0] absdiff(logic [SB-1:0] hi, logic [SB-1:0] lo);
        logic [SB:0] du;
        logic [SB:0] mag;
        du  = {hi[SB-1], hi} - {lo[SB-1], lo};
        mag = du[SB] ? (~du + (SB+1)'(1)) : du;
        return mag[SB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [mgm_pkg::CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic                      cfg_hit;
    logic [CW-1:0]             nx, ny, nz;

    assign cfg_ready = 1'b1;

    always_comb begin
        case (mgm_pkg::cfg_idx_t'(cfg_index))
            mgm_pkg::REG_SIZE_X: cfg_hit = cfg_valid;
            mgm_pkg::REG_SIZE_Y: cfg_hit = cfg_valid;
            mgm_pkg::REG_SIZE_Z: cfg_hit = cfg_valid;
            default:             cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= mgm_pkg::CFG_RESET;
            size_y_reg <= mgm_pkg::CFG_RESET;
            size_z_reg <= mgm_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (mgm_pkg::cfg_idx_t'(cfg_index))
                mgm_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                mgm_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                mgm_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign nx = eff_size(size_x_reg, MaxXC);
    assign ny = eff_size(size_y_reg, MaxYC);
    assign nz = eff_size(size_z_reg, MaxZC);

    // ------------------------------------------------------------------
    // Handshake and position counters
    // ------------------------------------------------------------------
    logic          en;                 // pipeline advance
    logic          accept, is_flush, do_voxel, do_emit, restart;
    logic          in_done_reg, in_done_next;
    logic [XB-1:0] ix_reg, ix_next, cx_reg, cx_next;
    logic [YB-1:0] iy_reg, iy_next, cy_reg, cy_next;
    logic [ZB-1:0] iz_reg, iz_next, cz_reg, cz_next;
    logic [1:0]    iym3_reg, iym3_next, cym3_reg, cym3_next;
    logic [RB-1:0] iyd3_reg, iyd3_next, cyd3_reg, cyd3_next;
    logic          ix_end, iy_end, iz_end, cx_end, cy_end, cz_end, c_last;
    logic [SB-1:0] sample;
    logic [SB+mgm_pkg::INT_W-1:0] sample_ext;

    assign s_ready  = en;
    assign accept   = s_valid && s_ready;
    assign is_flush = (s_data.cmd == mgm_pkg::CMD_FLUSH);
    assign do_voxel = accept && !is_flush && !in_done_reg;
    // A voxel of plane z>=1 releases the result beneath it; a flush drains
    // the final plane once every voxel is in.
    assign do_emit  = accept && (is_flush ? in_done_reg
                                          : (!in_done_reg && (iz_reg != '0)));

    assign ix_end = (CW'(ix_reg) + CW'(1) == nx);
    assign iy_end = (CW'(iy_reg) + CW'(1) == ny);
    assign iz_end = (CW'(iz_reg) + CW'(1) == nz);
    assign cx_end = (CW'(cx_reg) + CW'(1) == nx);
    assign cy_end = (CW'(cy_reg) + CW'(1) == ny);
    assign cz_end = (CW'(cz_reg) + CW'(1) == nz);
    assign c_last = cx_end && cy_end && cz_end;

    assign restart = (cfg_hit && cfg_ready) || (do_emit && c_last);

    assign sample_ext = {{SB{1'b0}}, s_data.intensity};
    assign sample     = sample_ext[SB-1:0];

    always_comb begin
        in_done_next = in_done_reg;
        ix_next      = ix_reg;
        iy_next      = iy_reg;
        iz_next      = iz_reg;
        iym3_next    = iym3_reg;
        iyd3_next    = iyd3_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        cym3_next    = cym3_reg;
        cyd3_next    = cyd3_reg;

        if (do_voxel) begin
            if (!ix_end) begin
                ix_next = ix_reg + XB'(1);
            end else begin
                ix_next = '0;
                if (!iy_end) begin
                    iy_next = iy_reg + YB'(1);
                    if (iym3_reg == 2'd2) begin
                        iym3_next = 2'd0;
                        iyd3_next = iyd3_reg + RB'(1);
                    end else begin
                        iym3_next = iym3_reg + 2'd1;
                    end
                end else begin
                    iy_next   = '0;
                    iym3_next = 2'd0;
                    iyd3_next = '0;
                    if (!iz_end) begin
                        iz_next = iz_reg + ZB'(1);
                    end else begin
                        iz_next      = '0;
                        in_done_next = 1'b1;
                    end
                end
            end
        end

        if (do_emit) begin
            if (!cx_end) begin
                cx_next = cx_reg + XB'(1);
            end else begin
                cx_next = '0;
                if (!cy_end) begin
                    cy_next = cy_reg + YB'(1);
                    if (cym3_reg == 2'd2) begin
                        cym3_next = 2'd0;
                        cyd3_next = cyd3_reg + RB'(1);
                    end else begin
                        cym3_next = cym3_reg + 2'd1;
                    end
                end else begin
                    cy_next   = '0;
                    cym3_next = 2'd0;
                    cyd3_next = '0;
                    cz_next   = cz_reg + ZB'(1);
                end
            end
        end

        if (restart) begin
            in_done_next = 1'b0;
            ix_next      = '0;
            iy_next      = '0;
            iz_next      = '0;
            iym3_next    = 2'd0;
            iyd3_next    = '0;
            cx_next      = '0;
            cy_next      = '0;
            cz_next      = '0;
            cym3_next    = 2'd0;
            cyd3_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_done_reg <= 1'b0;
            ix_reg      <= '0;
            iy_reg      <= '0;
            iz_reg      <= '0;
            iym3_reg    <= 2'd0;
            iyd3_reg    <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            cz_reg      <= '0;
            cym3_reg    <= 2'd0;
            cyd3_reg    <= '0;
        end else begin
            in_done_reg <= in_done_next;
            ix_reg      <= ix_next;
            iy_reg      <= iy_next;
            iz_reg      <= iz_next;
            iym3_reg    <= iym3_next;
            iyd3_reg    <= iyd3_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            cz_reg      <= cz_next;
            cym3_reg    <= cym3_next;
            cyd3_reg    <= cyd3_next;
        end
    end

    // ------------------------------------------------------------------
    // Banked plane store
    // ------------------------------------------------------------------
    logic [1:0]    ym_c, ym_p, ym_m;       // row mod 3 of y, y+1, y-1
    logic [RB-1:0] yd_c, yd_p, yd_m;       // row div 3 of y, y+1, y-1
    logic [XB:0]   cx_inc;
    logic [XHB-1:0] xh_c, xh_n, xh_w;
    logic [SB-1:0] rd_q [NBANK];

    assign ym_c   = cym3_reg;
    assign yd_c   = cyd3_reg;
    assign ym_p   = (ym_c == 2'd2) ? 2'd0 : ym_c + 2'd1;
    assign yd_p   = (ym_c == 2'd2) ? yd_c + RB'(1) : yd_c;
    assign ym_m   = (ym_c == 2'd0) ? 2'd2 : ym_c - 2'd1;
    assign yd_m   = (ym_c == 2'd0) ? yd_c - RB'(1) : yd_c;
    assign cx_inc = {1'b0, cx_reg} + (XB+1)'(1);
    assign xh_c   = XHB'(cx_reg >> 1);
    assign xh_n   = XHB'(cx_inc >> 1);
    assign xh_w   = XHB'(ix_reg >> 1);

    for (genvar g = 0; g < NBANK; g++) begin : g_bank
        localparam logic       BS  = 1'(g / 6);
        localparam logic [1:0] BY  = 2'((g / 2) % 3);
        localparam logic       BX  = 1'(g % 2);

        logic [RB-1:0]  row;
        logic [AW-1:0]  raddr;
        logic           we;

        // Each row bank serves the center row, the row above or the row below.
        assign row   = (BY == ym_c) ? yd_c : ((BY == ym_p) ? yd_p : yd_m);
        assign raddr = {row, (BX == cx_reg[0]) ? xh_c : xh_n};
        assign we    = do_voxel && (iz_reg[0] == BS) && (iym3_reg == BY)
                       && (ix_reg[0] == BX);

        mgm_bank #(
            .DW (SB),
            .AW (AW)
        ) u_bank (
            .aclk  (aclk),
            .we    (we),
            .waddr ({iyd3_reg, xh_w}),
            .wdata (sample),
            .re    (accept),
            .raddr (raddr),
            .rdata (rd_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: bank data and neighbor flags
    // ------------------------------------------------------------------
    mgm_pkg::tag_t s1_tag_reg;
    logic          s1_c_reg, s1_xp_reg;
    logic [1:0]    s1_mc_reg, s1_mp_reg, s1_mm_reg;
    logic          s1_xlo_reg, s1_xhi_reg, s1_ylo_reg, s1_yhi_reg, s1_zlo_reg;
    logic          s1_abv_reg;
    logic [SB-1:0] s1_above_reg;
    logic [SB-1:0] prev_reg;               // center of the previous result

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
        end else if (en) begin
            s1_tag_reg.valid <= do_emit;
            s1_tag_reg.last  <= c_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_c_reg     <= cz_reg[0];
            s1_xp_reg    <= cx_reg[0];
            s1_mc_reg    <= ym_c;
            s1_mp_reg    <= ym_p;
            s1_mm_reg    <= ym_m;
            s1_xlo_reg   <= (cx_reg != '0);
            s1_xhi_reg   <= (CW'(cx_reg) + CW'(1) < nx);
            s1_ylo_reg   <= (cy_reg != '0);
            s1_yhi_reg   <= (CW'(cy_reg) + CW'(1) < ny);
            s1_zlo_reg   <= (cz_reg != '0);
            s1_abv_reg   <= !is_flush;
            s1_above_reg <= sample;
        end
    end

    logic [SB-1:0] v, v_r, v_ym, v_yp, v_bl;
    logic [SB-1:0] xlo_v, xhi_v, ylo_v, yhi_v, zlo_v, zhi_v;
    logic [SB-1:0] ad_x_next, ad_y_next, ad_z_next;

    always_comb begin
        v     = rd_q[bidx(s1_c_reg, s1_mc_reg, s1_xp_reg)];
        v_r   = rd_q[bidx(s1_c_reg, s1_mc_reg, !s1_xp_reg)];
        v_ym  = rd_q[bidx(s1_c_reg, s1_mm_reg, s1_xp_reg)];
        v_yp  = rd_q[bidx(s1_c_reg, s1_mp_reg, s1_xp_reg)];
        v_bl  = rd_q[bidx(!s1_c_reg, s1_mc_reg, s1_xp_reg)];
        // clamped neighbors fall back on the center
        xlo_v = s1_xlo_reg ? prev_reg     : v;
        xhi_v = s1_xhi_reg ? v_r          : v;
        ylo_v = s1_ylo_reg ? v_ym         : v;
        yhi_v = s1_yhi_reg ? v_yp         : v;
        zlo_v = s1_zlo_reg ? v_bl         : v;
        zhi_v = s1_abv_reg ? s1_above_reg : v;
        ad_x_next = absdiff(xhi_v, xlo_v);
        ad_y_next = absdiff(yhi_v, ylo_v);
        ad_z_next = absdiff(zhi_v, zlo_v);
    end

    always_ff @(posedge aclk) begin
        if (en && s1_tag_reg.valid) begin
            prev_reg <= v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: absolute differences; stage 3: squares
    // ------------------------------------------------------------------
    mgm_pkg::tag_t   s2_tag_reg, s3_tag_reg;
    logic [SB-1:0]   ad_x_reg, ad_y_reg, ad_z_reg;
    logic            s2_ox_reg, s2_oy_reg, s2_oz_reg, s2_pos_reg;
    logic            s3_ox_reg, s3_oy_reg, s3_oz_reg, s3_pos_reg;
    logic [2*SB-1:0] sq_x_reg, sq_y_reg, sq_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end else if (en) begin
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ad_x_reg   <= ad_x_next;
            ad_y_reg   <= ad_y_next;
            ad_z_reg   <= ad_z_next;
            // one-sided difference where exactly one neighbor exists
            s2_ox_reg  <= s1_xlo_reg ^ s1_xhi_reg;
            s2_oy_reg  <= s1_ylo_reg ^ s1_yhi_reg;
            s2_oz_reg  <= s1_zlo_reg ^ s1_abv_reg;
            s2_pos_reg <= !v[SB-1] && (v != '0);
            sq_x_reg   <= ad_x_reg * ad_x_reg;
            sq_y_reg   <= ad_y_reg * ad_y_reg;
            sq_z_reg   <= ad_z_reg * ad_z_reg;
            s3_ox_reg  <= s2_ox_reg;
            s3_oy_reg  <= s2_oy_reg;
            s3_oz_reg  <= s2_oz_reg;
            s3_pos_reg <= s2_pos_reg;
        end
    end

    // Sum of four times each squared half-difference, then times 64 so the
    // root carries 4 fraction bits.
    logic [SW-1:0] sum_next;
    logic [NW-1:0] rad_next;

    always_comb begin
        sum_next = SW'(s3_ox_reg ? {sq_x_reg, 2'b00} : {2'b00, sq_x_reg})
                 + SW'(s3_oy_reg ? {sq_y_reg, 2'b00} : {2'b00, sq_y_reg})
                 + SW'(s3_oz_reg ? {sq_z_reg, 2'b00} : {2'b00, sq_z_reg});
        rad_next = s3_pos_reg ? {sum_next, 6'b000000} : '0;
    end

    mgm_pkg::tag_t  rt_tag;
    logic [K-1:0]   rt_root;

    mgm_sqrt #(
        .K (K)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_tag   (s3_tag_reg),
        .in_rad   (rad_next),
        .out_tag  (rt_tag),
        .out_root (rt_root)
    );

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    mgm_pkg::out_t              out_reg, skid_reg, pipe_out;
    logic                       out_valid_reg, skid_valid_reg, pipe_v, load_out;
    logic [K+mgm_pkg::MAG_W-1:0] root_ext;

    assign en       = !skid_valid_reg;
    assign pipe_v   = rt_tag.valid && en;
    assign load_out = !out_valid_reg || m_ready;
    assign root_ext = {{mgm_pkg::MAG_W{1'b0}}, rt_root};

    always_comb begin
        pipe_out.magnitude = root_ext[mgm_pkg::MAG_W-1:0];
        pipe_out.last      = rt_tag.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= pipe_v;
            end
        end else if (pipe_v) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= skid_valid_reg ? skid_reg : pipe_out;
        end else if (pipe_v) begin
            skid_reg <= pipe_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while the output is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    a_input_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        in_done_reg |-> (ix_reg == '0 && iy_reg == '0 && iz_reg == '0))
        else $error("input position not wrapped after the final voxel");

endmodule
